[sv/jsu_pkg.sv]
// shared types, character codes and helper functions for the json string unescaper
package jsu_pkg;

  // most result words one input word can cause, and the longest cut-short tail
  localparam int MaxRes    = 5;
  localparam int SeqLen    = 6;
  localparam int HoldDepth = 3;

  // character codes
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] CtlBs    = 8'h08;
  localparam logic [7:0] CtlFf    = 8'h0C;
  localparam logic [7:0] CtlLf    = 8'h0A;
  localparam logic [7:0] CtlCr    = 8'h0D;
  localparam logic [7:0] CtlTab   = 8'h09;

  // escape phase: idle, after backslash, after backslash-u with 0..3 chars held
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_U0   = 3'd2,
    PH_U1   = 3'd3,
    PH_U2   = 3'd4,
    PH_U3   = 3'd5
  } phase_t;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       last;
  } res_t;

  // everything one input word settles
  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [2:0]        cnt;
    phase_t            phase_nxt;
    logic              hold_we;
    logic [1:0]        hold_idx;
  } dec_t;

  // true for the seven short escape codes
  function automatic logic short_hit(input logic [7:0] c);
    logic hit;
    case (c)
      ChQuote, ChBslash, ChB, ChF, ChN, ChR, ChT: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // character that a short escape code stands for
  function automatic logic [7:0] short_map(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      ChB:     m = CtlBs;
      ChF:     m = CtlFf;
      ChN:     m = CtlLf;
      ChR:     m = CtlCr;
      ChT:     m = CtlTab;
      default: m = c;
    endcase
    return m;
  endfunction

  // {is hex digit, digit value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

[sv/jsu_decode.sv]
// decode of one input byte against the escape phase into a list of result words
module jsu_decode (
  input  jsu_pkg::phase_t                     phase,
  input  logic [jsu_pkg::HoldDepth-1:0][7:0]  held,
  input  logic [7:0]                          c,
  input  logic                                last,
  output jsu_pkg::dec_t                       dec
);

  logic [jsu_pkg::SeqLen:0][7:0] seq;
  logic [2:0]                    len;
  logic [2:0]                    n;
  logic                          skip;
  logic [4:0]                    hv0, hv1, hv2, hv3;

  // hex digit values of the held chars and the closing char
  assign hv0 = jsu_pkg::hex_val(held[0]);
  assign hv1 = jsu_pkg::hex_val(held[1]);
  assign hv2 = jsu_pkg::hex_val(held[2]);
  assign hv3 = jsu_pkg::hex_val(c);

  always_comb begin
    dec           = '0;
    dec.phase_nxt = jsu_pkg::PH_IDLE;
    seq           = '0;
    len           = 3'd0;
    n             = 3'd0;
    skip          = 1'b0;

    if (phase == jsu_pkg::PH_U3) begin
      // fourth char after backslash-u: value of the leading hex digits, low byte; bad if none
      n = 3'd1;
      if (hv0[4] && hv1[4] && hv2[4] && hv3[4]) begin
        dec.res[0].data = {hv2[3:0], hv3[3:0]};
      end else if (hv0[4] && hv1[4] && hv2[4]) begin
        dec.res[0].data = {hv1[3:0], hv2[3:0]};
      end else if (hv0[4] && hv1[4]) begin
        dec.res[0].data = {hv0[3:0], hv1[3:0]};
      end else if (hv0[4]) begin
        dec.res[0].data = {4'd0, hv0[3:0]};
      end else begin
        dec.res[0].bad = 1'b1;
      end
    end else if (last) begin
      // end of string: pending escape text goes out, short codes still apply
      case (phase)
        jsu_pkg::PH_ESC: begin
          seq[0] = jsu_pkg::ChBslash; seq[1] = c; len = 3'd2;
        end
        jsu_pkg::PH_U0: begin
          seq[0] = jsu_pkg::ChBslash; seq[1] = jsu_pkg::ChU; seq[2] = c; len = 3'd3;
        end
        jsu_pkg::PH_U1: begin
          seq[0] = jsu_pkg::ChBslash; seq[1] = jsu_pkg::ChU; seq[2] = held[0];
          seq[3] = c; len = 3'd4;
        end
        jsu_pkg::PH_U2: begin
          seq[0] = jsu_pkg::ChBslash; seq[1] = jsu_pkg::ChU; seq[2] = held[0];
          seq[3] = held[1]; seq[4] = c; len = 3'd5;
        end
        default: begin
          seq[0] = c; len = 3'd1;
        end
      endcase
      for (int i = 0; i < jsu_pkg::SeqLen; i++) begin
        if (3'(i) < len) begin
          if (skip) begin
            skip = 1'b0;
          end else if (3'(i) == len - 3'd1) begin
            dec.res[n].data = seq[i];
            n = n + 3'd1;
          end else if (seq[i] == jsu_pkg::ChBslash && jsu_pkg::short_hit(seq[i+1])) begin
            dec.res[n].data = jsu_pkg::short_map(seq[i+1]);
            n = n + 3'd1;
            skip = 1'b1;
          end else begin
            dec.res[n].data = seq[i];
            n = n + 3'd1;
          end
        end
      end
    end else begin
      case (phase)
        // after a backslash
        jsu_pkg::PH_ESC: begin
          if (jsu_pkg::short_hit(c)) begin
            dec.res[0].data = jsu_pkg::short_map(c);
            n = 3'd1;
          end else if (c == jsu_pkg::ChU) begin
            dec.phase_nxt = jsu_pkg::PH_U0;
          end else if (c == jsu_pkg::ChBslash) begin
            dec.res[0].data = jsu_pkg::ChBslash;
            n = 3'd1;
            dec.phase_nxt = jsu_pkg::PH_ESC;
          end else begin
            dec.res[0].data = jsu_pkg::ChBslash;
            dec.res[1].data = c;
            n = 3'd2;
          end
        end
        // collecting hex chars
        jsu_pkg::PH_U0, jsu_pkg::PH_U1, jsu_pkg::PH_U2: begin
          dec.hold_we   = 1'b1;
          dec.hold_idx  = 2'(phase - jsu_pkg::PH_U0);
          dec.phase_nxt = jsu_pkg::phase_t'(phase + 3'd1);
        end
        default: begin
          if (c == jsu_pkg::ChBslash) begin
            dec.phase_nxt = jsu_pkg::PH_ESC;
          end else begin
            dec.res[0].data = c;
            n = 3'd1;
          end
        end
      endcase
    end

    // count and end-of-string mark on the final word
    dec.cnt = n;
    if (last && n != 3'd0) begin
      dec.res[n - 3'd1].last = 1'b1;
    end
  end

endmodule

[sv/jsu_outq.sv]
// pending result list and output register, one result word out per unstalled cycle
module jsu_outq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  jsu_pkg::res_t [jsu_pkg::MaxRes-1:0]  res,
  input  logic [2:0]                           cnt,
  output logic                                 ready,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata,
  output logic                                 out_tlast,
  output logic [0:0]                           out_tuser
);

  jsu_pkg::res_t [jsu_pkg::MaxRes-1:0] pend_r, pend_nxt;
  logic [2:0]                          cnt_r, cnt_nxt;
  jsu_pkg::res_t                       oreg_r, oreg_nxt;
  logic                                ovld_r, ovld_nxt;
  logic                                take;

  // output register frees when empty or taken; input may load as the list runs dry
  assign take  = !ovld_r || out_tready;
  assign ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && take);

  // list shift and reload
  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    oreg_nxt = oreg_r;
    ovld_nxt = ovld_r;
    if (take) begin
      if (cnt_r != 3'd0) begin
        oreg_nxt = pend_r[0];
        ovld_nxt = 1'b1;
        pend_nxt = {jsu_pkg::res_t'('0), pend_r[jsu_pkg::MaxRes-1:1]};
        cnt_nxt  = cnt_r - 3'd1;
      end else begin
        ovld_nxt = 1'b0;
      end
    end
    if (load) begin
      pend_nxt = res;
      cnt_nxt  = cnt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      ovld_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    oreg_r <= oreg_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = oreg_r.data;
  assign out_tlast  = oreg_r.last;
  assign out_tuser  = oreg_r.bad;

endmodule

[sv/json_string_unescape_top.sv]
// top level of the json string unescaper: escape state, decode and output queue
//
//  channel | dir | tdata (low bit up) | tlast         | tuser
//  in_     | in  | [7:0] in_byte      | in_last       | -
//  out_    | out | [7:0] out_byte     | out_last      | [0] bad_hex
//
//  an input word is decoded in the cycle it is accepted into a list of 0 to 5 result
//  words; the list drains through the output register at one word per cycle while
//  the output is not stalled, so a word with k results gives k output words, and a new input
//  word is taken each cycle while the list is empty or its one remaining result moves on
//  reset (rst_n low, synchronous) returns the escape phase to idle and empties the queue
//  out_tready low holds the output word and, while a result waits in the list, in_tready
module json_string_unescape_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [0:0] out_tuser   // [0] bad_hex
);

  jsu_pkg::phase_t                      phase_r, phase_nxt;
  logic [jsu_pkg::HoldDepth-1:0][7:0]   held_r, held_nxt;
  jsu_pkg::dec_t                        dec;
  logic                                 in_fire;

  assign in_fire = in_tvalid && in_tready;

  jsu_decode u_decode (
    .phase (phase_r),
    .held  (held_r),
    .c     (in_tdata),
    .last  (in_tlast),
    .dec   (dec)
  );

  jsu_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .res        (dec.res),
    .cnt        (dec.cnt),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // escape state update on each accepted word
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (in_fire) begin
      phase_nxt = dec.phase_nxt;
      if (dec.hold_we) begin
        held_nxt[dec.hold_idx] = in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsu_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // held hex chars, written before read
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

[sv/jsu_check.sv]
// port checker for the json string unescaper, bound to the top level
module jsu_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);

  // no output word right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid after reset");

  // input side open right after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // a stalled output word stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  // a stalled output word keeps its contents
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
                                 && $stable(out_tuser))
    else $error("output word changed while stalled");

  // a word flagged bad (u escape whose first char is no hex digit) carries a zero byte
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 8'd0)
    else $error("bad hex word with nonzero byte");

endmodule

bind json_string_unescape_top jsu_check u_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
